/* rtl/pem_pkg.sv */
// Shared types and constants for the Prewitt edge magnitude block.
// No dependencies; every other file imports this package.
package pem_pkg;

	localparam int MAX_WIDTH = 1024;
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int ROW_W     = 12;
	localparam int PIX_W     = 8;
	localparam int WIDTH_W   = 11;
	localparam int HEIGHT_W  = 12;
	localparam int CFG_W     = 12;
	localparam int LB_W      = 2 * PIX_W;
	localparam int GRAD_W    = 11;
	localparam int SQ_W      = 20;
	localparam int ROOT_IN_W = 16;

	localparam logic [PIX_W-1:0] MAG_MAX = 8'd255;

	typedef enum logic [0:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_index_t;

	typedef struct packed {
		logic [PIX_W-1:0] edge_value;
		logic [ROW_W-1:0] out_row;
		logic [COL_W-1:0] out_col;
		logic             is_border;
		logic             last_in_run;
		logic             frame_end;
	} pem_result_t;

	typedef struct packed {
		logic                 start;
		logic [ROOT_IN_W-1:0] operand;
	} root_req_t;

	typedef struct packed {
		logic             done;
		logic [PIX_W-1:0] root;
	} root_rsp_t;

endpackage

/* rtl/pem_if.sv */
// Valid/ready channel interfaces for pixel beats and result beats.
// Depends on pem_pkg.
interface pem_pix_if import pem_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_value;

	modport source (output valid, output pixel_value, input ready);
	modport sink (input valid, input pixel_value, output ready);
endinterface

interface pem_res_if import pem_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] edge_value;
	logic [ROW_W-1:0] out_row;
	logic [COL_W-1:0] out_col;
	logic             is_border;
	logic             last_in_run;
	logic             frame_end;

	modport source (output valid, output edge_value, output out_row, output out_col,
		output is_border, output last_in_run, output frame_end, input ready);
	modport sink (input valid, input edge_value, input out_row, input out_col,
		input is_border, input last_in_run, input frame_end, output ready);
endinterface

/* rtl/pem_linebuf.sv */
// Line buffer memory: one entry per column holding {older row, newer row}.
// Synchronous read; data appears the cycle after rd_en. Depends on pem_pkg.
module pem_linebuf import pem_pkg::*; (
	input  logic            clk,
	input  logic            rd_en,
	input  logic [COL_W-1:0] rd_addr,
	output logic [LB_W-1:0]  rd_data,
	input  logic            wr_en,
	input  logic [COL_W-1:0] wr_addr,
	input  logic [LB_W-1:0]  wr_data
);

	logic [LB_W-1:0] mem_q [MAX_WIDTH];

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

endmodule

/* rtl/pem_isqrt.sv */
// Iterative integer square root of a 16-bit value, two result bits per cycle.
// Depends on pem_pkg.
module pem_isqrt import pem_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  root_req_t req,
	output root_rsp_t rsp
);

	localparam int STEPS_PER_CYCLE = 2;
	localparam int CYCLES          = ROOT_IN_W / (2 * STEPS_PER_CYCLE);
	localparam int CNT_W           = $clog2(CYCLES);

	logic [ROOT_IN_W-1:0] rem_q, res_q, bit_q;
	logic [ROOT_IN_W-1:0] rem_d, res_d, bit_d;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q, done_q;

	// Restoring square root: each step settles one result bit.
	always_comb begin
		logic [ROOT_IN_W:0] trial;
		rem_d = rem_q;
		res_d = res_q;
		bit_d = bit_q;
		for (int k = 0; k < STEPS_PER_CYCLE; k++) begin
			trial = {1'b0, res_d} + {1'b0, bit_d};
			if ({1'b0, rem_d} >= trial) begin
				rem_d = rem_d - trial[ROOT_IN_W-1:0];
				res_d = (res_d >> 1) + bit_d;
			end else begin
				res_d = res_d >> 1;
			end
			bit_d = bit_d >> 2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(CYCLES - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.operand;
			res_q <= '0;
			bit_q <= ROOT_IN_W'(1) << (ROOT_IN_W - 2);
		end else if (busy_q) begin
			rem_q <= rem_d;
			res_q <= res_d;
			bit_q <= bit_d;
		end
	end

	assign rsp.done = done_q;
	assign rsp.root = res_q[PIX_W-1:0];

endmodule

/* rtl/pem_outq.sv */
// Two-entry result queue driving the result channel.
// Depends on pem_pkg and pem_res_if.
module pem_outq import pem_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  pem_result_t   push_data,
	output logic          full,
	pem_res_if.source     result
);

	pem_result_t ent_q [2];
	logic        wr_ptr_q, rd_ptr_q;
	logic [1:0]  count_q;
	logic        pop;
	pem_result_t head;

	assign pop  = result.valid && result.ready;
	assign full = (count_q == 2'd2);
	assign head = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

	assign result.valid       = (count_q != 2'd0);
	assign result.edge_value  = head.edge_value;
	assign result.out_row     = head.out_row;
	assign result.out_col     = head.out_col;
	assign result.is_border   = head.is_border;
	assign result.last_in_run = head.last_in_run;
	assign result.frame_end   = head.frame_end;

endmodule

/* rtl/prewitt_edge_magnitude_3x3.sv */
// Streaming 3x3 Prewitt edge magnitude over a raster-order gray frame.
// Gray pixels arrive as beats on the pixel channel (valid/ready); results leave
// as beats on the result channel, each tagged with its row and column.
// A pixel on the first or last row or column is passed through as a border
// result. The interior pixel one row up and one column left is emitted when a
// pixel arrives, as floor(sqrt(gx^2 + gy^2)) clamped to 255, before the border
// result of the same pixel. last_in_run marks the final result of a pixel and
// frame_end the result of the frame's last pixel.
// One pixel at a time: a new pixel is accepted only once the sequencer is idle.
// A pixel that yields no result (second row or column, off the border) goes
// through the line memory read and write back; one that yields only a border
// result adds the queue push; a pixel with an interior result also passes the
// gradient and squaring stages and the iterative square root unit before its
// push, followed by its border push if it has one.
// Results go into a two-entry queue, so the next pixel is taken while results
// wait; when the receiver stalls and the queue is full, the sequencer holds.
// Reset returns the counters to row 0, column 0, clears the window and sets
// the frame to 640 x 480; line memory contents are not cleared.
// Config writes (wr_en, wr_index, wr_data) are meant for idle periods.
// Depends on pem_pkg, pem_if, pem_linebuf, pem_isqrt, pem_outq.
module prewitt_edge_magnitude_3x3 import pem_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [0:0]       wr_index,
	input  logic [CFG_W-1:0] wr_data,
	pem_pix_if.sink          pixel,
	pem_res_if.source        result
);

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_READ = 8'b0000_0010,
		S_GRAD = 8'b0000_0100,
		S_SQR  = 8'b0000_1000,
		S_ROOT = 8'b0001_0000,
		S_WAIT = 8'b0010_0000,
		S_INT  = 8'b0100_0000,
		S_BORD = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	// configuration
	logic [WIDTH_W-1:0]  width_q;
	logic [HEIGHT_W-1:0] height_q;
	logic [COL_W-1:0]    w_last;
	logic [ROW_W-1:0]    h_last;

	// position counters and per-pixel context
	logic [ROW_W-1:0] row_q, r_q;
	logic [COL_W-1:0] col_q, c_q;
	logic [PIX_W-1:0] p_q;
	logic             interior_q, border_q, fend_q;
	logic             accept, last_col, last_row, interior, border;

	// window and arithmetic
	logic [PIX_W-1:0]        win_q [9];
	logic signed [GRAD_W-1:0] gx_q, gy_q, gx_d, gy_d;
	logic [SQ_W-1:0]          gx2_q, gy2_q;
	logic [SQ_W:0]            mag_sum;
	logic                     sat_q;

	// submodule wiring
	logic [LB_W-1:0] lb_rd_data;
	logic            lb_wr_en;
	root_req_t       root_req;
	root_rsp_t       root_rsp;
	logic            oq_full, push;
	pem_result_t     push_data;

	// Config register file, written by index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_W'(640);
			height_q <= HEIGHT_W'(480);
		end else if (wr_en) begin
			unique case (cfg_index_t'(wr_index))
				REG_IMAGE_WIDTH:  width_q  <= wr_data[WIDTH_W-1:0];
				REG_IMAGE_HEIGHT: height_q <= wr_data[HEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective last column and row: width clamped to [3, MAX_WIDTH], height at least 3.
	always_comb begin
		if (width_q > WIDTH_W'(MAX_WIDTH)) begin
			w_last = COL_W'(MAX_WIDTH - 1);
		end else if (width_q < WIDTH_W'(3)) begin
			w_last = COL_W'(2);
		end else begin
			w_last = COL_W'(width_q - 1'b1);
		end
		if (height_q < HEIGHT_W'(3)) begin
			h_last = ROW_W'(2);
		end else begin
			h_last = ROW_W'(height_q - 1'b1);
		end
	end

	assign accept   = pixel.valid && pixel.ready;
	assign last_col = (col_q >= w_last);
	assign last_row = (row_q >= h_last);
	assign interior = (row_q >= ROW_W'(2)) && (row_q <= h_last)
		&& (col_q >= COL_W'(2)) && (col_q <= w_last);
	assign border   = (row_q == '0) || last_row || (col_q == '0) || last_col;

	assign pixel.ready = (state_q == S_IDLE);

	// Raster counters: wrap the column at the last one, the row at the frame end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// Capture the pixel and its position context at accept.
	always_ff @(posedge clk) begin
		if (accept) begin
			p_q        <= pixel.pixel_value;
			r_q        <= row_q;
			c_q        <= col_q;
			interior_q <= interior;
			border_q   <= border;
			fend_q     <= last_row && last_col;
		end
	end

	// Read the column's two older rows at accept; write back {newer, pixel} next cycle.
	assign lb_wr_en = (state_q == S_READ);

	pem_linebuf u_linebuf (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (col_q),
		.rd_data (lb_rd_data),
		.wr_en   (lb_wr_en),
		.wr_addr (c_q),
		.wr_data ({lb_rd_data[PIX_W-1:0], p_q})
	);

	// Shift the window left and insert the new column on the right.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= '0;
			end
		end else if (state_q == S_READ) begin
			for (int row = 0; row < 3; row++) begin
				win_q[row*3]     <= win_q[row*3 + 1];
				win_q[row*3 + 1] <= win_q[row*3 + 2];
			end
			win_q[2] <= lb_rd_data[LB_W-1:PIX_W];
			win_q[5] <= lb_rd_data[PIX_W-1:0];
			win_q[8] <= p_q;
		end
	end

	// Prewitt gradients: right column minus left, bottom row minus top.
	always_comb begin
		gx_d = '0;
		gy_d = '0;
		for (int row = 0; row < 3; row++) begin
			gx_d = gx_d + $signed({3'b000, win_q[row*3 + 2]}) - $signed({3'b000, win_q[row*3]});
			gy_d = gy_d + $signed({3'b000, win_q[6 + row]}) - $signed({3'b000, win_q[row]});
		end
	end

	assign mag_sum = {1'b0, gx2_q} + {1'b0, gy2_q};

	always_ff @(posedge clk) begin
		if (state_q == S_GRAD) begin
			gx_q <= gx_d;
			gy_q <= gy_d;
		end
		if (state_q == S_SQR) begin
			gx2_q <= SQ_W'(gx_q * gx_q);
			gy2_q <= SQ_W'(gy_q * gy_q);
		end
		if (state_q == S_ROOT) begin
			sat_q <= (mag_sum >= (SQ_W + 1)'(1 << ROOT_IN_W));
		end
	end

	// A sum of 65536 or more saturates; the root unit sees only the low bits then.
	assign root_req.start   = (state_q == S_ROOT);
	assign root_req.operand = mag_sum[ROOT_IN_W-1:0];

	pem_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (root_req),
		.rsp    (root_rsp)
	);

	// Result selection: interior result first, then the border pass-through.
	always_comb begin
		push      = 1'b0;
		push_data = '0;
		if (state_q == S_INT) begin
			push                  = !oq_full;
			push_data.edge_value  = sat_q ? MAG_MAX : root_rsp.root;
			push_data.out_row     = r_q - 1'b1;
			push_data.out_col     = c_q - 1'b1;
			push_data.is_border   = 1'b0;
			push_data.last_in_run = !border_q;
			push_data.frame_end   = 1'b0;
		end else if (state_q == S_BORD) begin
			push                  = !oq_full;
			push_data.edge_value  = p_q;
			push_data.out_row     = r_q;
			push_data.out_col     = c_q;
			push_data.is_border   = 1'b1;
			push_data.last_in_run = 1'b1;
			push_data.frame_end   = fend_q;
		end
	end

	pem_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (oq_full),
		.result    (result)
	);

	// Sequencer: one pixel at a time; hold in a push state while the queue is full.
	// A pixel that is neither interior-completing nor border drops straight back to idle.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (accept) state_d = S_READ;
			S_READ: begin
				if (interior_q) state_d = S_GRAD;
				else if (border_q) state_d = S_BORD;
				else state_d = S_IDLE;
			end
			S_GRAD: state_d = S_SQR;
			S_SQR:  state_d = S_ROOT;
			S_ROOT: state_d = S_WAIT;
			S_WAIT: if (root_rsp.done) state_d = S_INT;
			S_INT: begin
				if (push) state_d = border_q ? S_BORD : S_IDLE;
			end
			S_BORD: if (push) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef ASSERT_OFF
	// The queue must never take a beat while full.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !oq_full)
		else $error("result queue overflow");

	// An accepted pixel always moves on to its memory read cycle.
	a_accept_read: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_READ))
		else $error("accepted pixel did not advance to read");

	// The root unit only finishes while the sequencer waits for it.
	a_root_done: assert property (@(posedge clk) disable iff (!arst_n)
		root_rsp.done |-> (state_q == S_WAIT))
		else $error("square root finished outside wait");

	// After the interior result of a border pixel, its border result follows.
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INT) && push && border_q |=> (state_q == S_BORD))
		else $error("border result did not follow interior result");
`endif

endmodule
